FILE: sv/pialu_pkg.sv
// package for the preprocessor integer alu: operator and error codes
// no dependencies
package pialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [4:0] {
        OP_MUL  = 5'd0,
        OP_DIV  = 5'd1,
        OP_MOD  = 5'd2,
        OP_ADD  = 5'd3,
        OP_SUB  = 5'd4,
        OP_SHL  = 5'd5,
        OP_SHR  = 5'd6,
        OP_AND  = 5'd7,
        OP_XOR  = 5'd8,
        OP_OR   = 5'd9,
        OP_LAND = 5'd10,
        OP_LOR  = 5'd11,
        OP_NE   = 5'd12,
        OP_EQ   = 5'd13,
        OP_GT   = 5'd14,
        OP_GE   = 5'd15,
        OP_LT   = 5'd16,
        OP_LE   = 5'd17
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_CONV  = 3'd1,
        ERR_DIV0  = 3'd2,
        ERR_QOVF  = 3'd3,
        ERR_BADOP = 3'd4
    } err_t;

    // per-item control carried along the divider pipeline
    typedef struct packed {
        logic       is_div;
        logic       neg_q;
        logic       neg_r;
    } div_ctl_t;

endpackage

FILE: sv/preproc_int_binary_alu.sv
// top level of the preprocessor integer binary operator alu
// depends on pialu_pkg and pialu_div
//
//  channel | signals                                           | dir
//  in      | valid, ready, op, left/right value and signedness | in
//  out     | valid, ready, result_value/signed, error_code     | out
//
// DATA_WIDTH+2 register stages: input registers, the divider's one-bit-per-stage
// pipeline and its output register; one request per cycle while the output is
// not stalled; every operation goes through the pipeline.
// the whole pipeline advances when the output slot is free or being taken;
// a stall freezes all stages together, so nothing is lost or repeated.
// reset clears the valid bits only.
module preproc_int_binary_alu #(
    parameter int DATA_WIDTH = pialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  ready,
    input  logic [4:0]            op,
    input  logic [DATA_WIDTH-1:0] left_value,
    input  logic                  left_is_signed,
    input  logic [DATA_WIDTH-1:0] right_value,
    input  logic                  right_is_signed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic                  result_is_signed,
    output logic [2:0]            error_code
);
    import pialu_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int DEPTH = W + 2;
    localparam int TW = W + 1 + 3 + 1;

    logic adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv   = !out_valid || out_ready;
    assign ready = adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], valid};
    end

    // stage 1: register inputs
    logic [4:0]   op_reg;
    logic [W-1:0] a_reg, b_reg;
    logic         as_reg, bs_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg <= op;
            a_reg  <= left_value;
            b_reg  <= right_value;
            as_reg <= left_is_signed;
            bs_reg <= right_is_signed;
        end
    end

    // stage 2: everything but division, plus divider operands
    logic         sgn;
    logic [2:0]   err;
    logic [W-1:0] r;
    logic         lt_ab, lt_ba, is_divop;
    logic [W-1:0] sa, sb;
    logic [W-1:0] sh;
    logic [W-1:0] mul_lo;
    logic [2*W-1:0] prod;
    logic [W-1:0] ma, mb;

    always_comb
    begin
        sgn = as_reg || bs_reg;
        err = ERR_OK;
        if ((as_reg && !bs_reg && b_reg[W-1]) || (bs_reg && !as_reg && a_reg[W-1]))
            err = ERR_CONV;
        sa = a_reg ^ {sgn, {(W-1){1'b0}}};
        sb = b_reg ^ {sgn, {(W-1){1'b0}}};
        sh = b_reg & W'(W - 1);
        lt_ab = sa < sb;
        lt_ba = sb < sa;
        prod = a_reg * b_reg;
        mul_lo = prod[W-1:0];
        ma = (sgn && a_reg[W-1]) ? W'(-a_reg) : a_reg;
        mb = (sgn && b_reg[W-1]) ? W'(-b_reg) : b_reg;
        is_divop = 1'b0;
        r = '0;
        case (op_reg)
            OP_MUL:  r = mul_lo;
            OP_DIV, OP_MOD:
            begin
                if (b_reg == '0)
                    err = ERR_DIV0;
                else if (sgn && a_reg == {1'b1, {(W-1){1'b0}}} && b_reg == '1)
                    err = ERR_QOVF;
                else
                    is_divop = 1'b1;
            end
            OP_ADD:  r = a_reg + b_reg;
            OP_SUB:  r = a_reg - b_reg;
            OP_SHL:  r = a_reg << sh;
            OP_SHR:  r = W'($signed({sgn & a_reg[W-1], a_reg}) >>> sh);
            OP_AND:  r = a_reg & b_reg;
            OP_XOR:  r = a_reg ^ b_reg;
            OP_OR:   r = a_reg | b_reg;
            OP_LAND: r = W'((a_reg != '0) && (b_reg != '0));
            OP_LOR:  r = W'((a_reg != '0) || (b_reg != '0));
            OP_NE:   r = W'(a_reg != b_reg);
            OP_EQ:   r = W'(a_reg == b_reg);
            OP_GT:   r = W'(lt_ba);
            OP_GE:   r = W'(!lt_ab);
            OP_LT:   r = W'(lt_ab);
            OP_LE:   r = W'(!lt_ba);
            default:
            begin
                r   = '1;
                sgn = 1'b0;
                err = ERR_BADOP;
            end
        endcase
    end

    div_ctl_t dctl;
    assign dctl.is_div = (op_reg == OP_DIV);
    assign dctl.neg_q  = sgn && (a_reg[W-1] != b_reg[W-1]);
    assign dctl.neg_r  = sgn && a_reg[W-1];

    logic [TW-1:0] tag_in, tag_out;
    logic [W-1:0]  quo;
    assign tag_in = {r, sgn, err, is_divop};

    pialu_div #(.W(W), .TW(TW)) u_div (
        .clk     (clk),
        .adv     (adv),
        .num     (is_divop ? ma : '0),
        .den     (is_divop ? mb : W'(1)),
        .ctl_in  (dctl),
        .tag_in  (tag_in),
        .quo     (quo),
        .tag_out (tag_out)
    );

    assign result_value     = tag_out[0] ? quo : tag_out[TW-1:5];
    assign result_is_signed = tag_out[4];
    assign error_code       = tag_out[3:1];

endmodule

FILE: sv/pialu_div.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on pialu_pkg
module pialu_div #(
    parameter int W = pialu_pkg::DATA_WIDTH_DEF,
    parameter int TW = 4
) (
    input  logic                  clk,
    input  logic                  adv,
    input  logic [W-1:0]          num,
    input  logic [W-1:0]          den,
    input  pialu_pkg::div_ctl_t   ctl_in,
    input  logic [TW-1:0]         tag_in,
    output logic [W-1:0]          quo,
    output logic [TW-1:0]         tag_out
);
    import pialu_pkg::*;

    logic [W-1:0] rem_reg [0:W];
    logic [W-1:0] q_reg   [0:W];
    logic [W-1:0] d_reg   [0:W];
    div_ctl_t     c_reg   [0:W];
    logic [TW-1:0] t_reg  [0:W];

    always_comb
    begin
        rem_reg[0] = '0;
        q_reg[0]   = num;
        d_reg[0]   = den;
        c_reg[0]   = ctl_in;
        t_reg[0]   = tag_in;
    end

    genvar i;
    generate
        for (i = 0; i < W; i++)
        begin : g_stage
            logic [W:0]   trial;
            logic [W:0]   diff;
            always_comb
            begin
                trial = {rem_reg[i], q_reg[i][W-1]};
                diff  = trial - {1'b0, d_reg[i]};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!diff[W])
                        rem_reg[i+1] <= diff[W-1:0];
                    else
                        rem_reg[i+1] <= trial[W-1:0];
                    q_reg[i+1] <= {q_reg[i][W-2:0], ~diff[W]};
                    d_reg[i+1] <= d_reg[i];
                    c_reg[i+1] <= c_reg[i];
                    t_reg[i+1] <= t_reg[i];
                end
            end
        end
    endgenerate

    // sign fix and quotient/remainder select
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (c_reg[W].is_div)
                quo <= c_reg[W].neg_q ? W'(-q_reg[W]) : q_reg[W];
            else
                quo <= c_reg[W].neg_r ? W'(-rem_reg[W]) : rem_reg[W];
            tag_out <= t_reg[W];
        end
    end

endmodule

FILE: sim/pialu_checker.sv
// checker for the preprocessor integer alu: watches both channels, predicts each
// result from the accepted request and compares it field by field
// depends on pialu_pkg
module pialu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic        ready,
    input  logic [4:0]  op,
    input  logic [31:0] left_value,
    input  logic        left_is_signed,
    input  logic [31:0] right_value,
    input  logic        right_is_signed,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] result_value,
    input  logic        result_is_signed,
    input  logic [2:0]  error_code,
    output int          fail_count,
    output int          pending
);
    import pialu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        is_signed;
        logic [2:0]  err;
    } alu_result_t;

    alu_result_t result_fifo[$];

    function automatic logic signed_less(logic [31:0] a, logic [31:0] b, logic sgn);
        if (sgn)
            return $signed(a) < $signed(b);
        return a < b;
    endfunction

    function automatic alu_result_t compute_alu(logic [4:0] code, logic [31:0] a, logic as,
                                                logic [31:0] b, logic bs);
        alu_result_t res;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [4:0]  sh;
        res.err = ERR_OK;
        res.value = '0;
        if ((as && !bs && b[31]) || (bs && !as && a[31]))
            res.err = ERR_CONV;
        res.is_signed = as || bs;
        sh = b[4:0];
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (code)
            OP_MUL: res.value = a * b;
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                    res.err = ERR_DIV0;
                else if (res.is_signed && a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                    res.err = ERR_QOVF;
                else if (res.is_signed)
                begin
                    if (code == OP_DIV)
                        res.value = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                    else
                        res.value = a[31] ? -(ma % mb) : ma % mb;
                end
                else
                    res.value = (code == OP_DIV) ? a / b : a % b;
            end
            OP_ADD:  res.value = a + b;
            OP_SUB:  res.value = a - b;
            OP_SHL:  res.value = a << sh;
            OP_SHR:  res.value = res.is_signed ? 32'($signed(a) >>> sh) : a >> sh;
            OP_AND:  res.value = a & b;
            OP_XOR:  res.value = a ^ b;
            OP_OR:   res.value = a | b;
            OP_LAND: res.value = 32'(a != 0 && b != 0);
            OP_LOR:  res.value = 32'(a != 0 || b != 0);
            OP_NE:   res.value = 32'(a != b);
            OP_EQ:   res.value = 32'(a == b);
            OP_GT:   res.value = 32'(signed_less(b, a, res.is_signed));
            OP_GE:   res.value = 32'(!signed_less(a, b, res.is_signed));
            OP_LT:   res.value = 32'(signed_less(a, b, res.is_signed));
            OP_LE:   res.value = 32'(!signed_less(b, a, res.is_signed));
            default:
            begin
                res.value = '1;
                res.is_signed = 1'b0;
                res.err = ERR_BADOP;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        alu_result_t exp_res;
        if (rst_n)
        begin
            if (valid && ready)
                result_fifo.push_back(compute_alu(op, left_value, left_is_signed,
                                                  right_value, right_is_signed));
            if (out_valid && out_ready)
            begin
                if (result_fifo.size() == 0)
                begin
                    $error("result with no request outstanding: %h", result_value);
                    fail_count++;
                end
                else
                begin
                    exp_res = result_fifo.pop_front();
                    if (result_value !== exp_res.value)
                    begin
                        $error("result_value expected %h got %h", exp_res.value, result_value);
                        fail_count++;
                    end
                    if (result_is_signed !== exp_res.is_signed)
                    begin
                        $error("result_is_signed expected %b got %b", exp_res.is_signed,
                               result_is_signed);
                        fail_count++;
                    end
                    if (error_code !== exp_res.err)
                    begin
                        $error("error_code expected %0d got %0d", exp_res.err, error_code);
                        fail_count++;
                    end
                end
            end
        end
        pending = result_fifo.size();
    end
endmodule

FILE: sim/tb_preproc_int_binary_alu.sv
// testbench top for the preprocessor integer alu: directed and random requests
// with random idling and stalls; verdict from pialu_checker
// depends on pialu_pkg, pialu_checker and preproc_int_binary_alu
module tb_preproc_int_binary_alu;
    import pialu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        ready;
    logic [4:0]  op = '0;
    logic [31:0] left_value = '0;
    logic        left_is_signed = 1'b0;
    logic [31:0] right_value = '0;
    logic        right_is_signed = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_value;
    logic        result_is_signed;
    logic [2:0]  error_code;
    int          fail_count;
    int          pending;
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    preproc_int_binary_alu i_dut (.*);

    pialu_checker i_checker (.*);

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'($urandom_range(0, 40));
            5: return -32'($urandom_range(1, 40));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic [4:0] code, logic [31:0] a, logic as,
                                logic [31:0] b, logic bs);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        valid <= 1'b1;
        op <= code;
        left_value <= a;
        left_is_signed <= as;
        right_value <= b;
        right_is_signed <= bs;
        @(posedge clk);
        while (!ready) @(posedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int i;
        logic [4:0] code;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 18; i++)
            send_request(5'(i), 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_DIV, 32'd7, 1'b1, 32'd0, 1'b0);
        send_request(OP_MOD, 32'hFFFF_FFF9, 1'b1, 32'd2, 1'b1);
        send_request(OP_SHR, 32'hFFFF_0000, 1'b1, 32'd36, 1'b0);
        send_request(OP_SHL, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_request(5'd31, 32'h1234_5678, 1'b0, 32'h9, 1'b1);
        send_request(5'd18, 32'h0, 1'b1, 32'h0, 1'b1);

        long_hold = 1'b1;
        for (i = 0; i < 950; i++)
        begin
            if (i == 880)
                quiet = 1'b1;
            if (i == 400)
            begin
                valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            code = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(18, 31))
                                                : 5'($urandom_range(0, 17));
            send_request(code, pick_operand(), 1'($urandom), pick_operand(), 1'($urandom));
        end
        valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
sv/pialu_pkg.sv
sv/pialu_div.sv
sv/preproc_int_binary_alu.sv
sim/pialu_checker.sv
sim/tb_preproc_int_binary_alu.sv
